FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// The clock and reset names are the ones used at the top level's ports.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/acgt_pkg.sv
// ----------------------------------------------------------------------------
// acgt_pkg
// Sizes, command and status codes and sequencer states of the goto table build.
// ----------------------------------------------------------------------------
package acgt_pkg;

   localparam int ALPHABET   = 26;
   localparam int MAX_NODES  = 4096;
   localparam int NODE_W     = 12;
   localparam int SYM_W      = 5;
   localparam int CNT_W      = 13;
   localparam int GOTO_DEPTH = ALPHABET * MAX_NODES;
   localparam int GOTO_AW    = $clog2(GOTO_DEPTH);

   localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(ALPHABET - 1);

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_END    = 2'd1;
   localparam logic [1:0] CMD_BUILD  = 2'd2;
   localparam logic [1:0] CMD_LOOKUP = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD,
      S_DATA,
      S_DEPD,
      B_POP,
      B_POPD,
      B_FAIL,
      B_ADDR,
      B_RDE,
      B_RDF,
      B_ACT
   } state_type;

endpackage

FILE: rtl/acgt_addr.sv
// ----------------------------------------------------------------------------
// acgt_addr
// Shared address unit: registered row base plus symbol into the goto table.
// ----------------------------------------------------------------------------
module acgt_addr (
   input  logic                             clock,
   input  logic [acgt_pkg::NODE_W-1:0]      node,
   input  logic [acgt_pkg::SYM_W-1:0]       sym,
   output logic [acgt_pkg::GOTO_AW-1:0]     addr
);

   logic [acgt_pkg::GOTO_AW-1:0] addr_ff;
   logic [acgt_pkg::GOTO_AW-1:0] addr_in;

   // One narrow constant multiply and one add per cycle.
   assign addr_in = acgt_pkg::GOTO_AW'(node) * acgt_pkg::GOTO_AW'(acgt_pkg::ALPHABET)
                  + acgt_pkg::GOTO_AW'(sym);

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign addr = addr_ff;

endmodule

FILE: rtl/aho_corasick_goto_table_build.sv
// ----------------------------------------------------------------------------
// aho_corasick_goto_table_build
// After reset a clearing pass over all ALPHABET*MAX_NODES (106496) goto entries
// zeroes the goto, failure and depth tables with req_ready low. One command is
// in work at a time; req_ready is low until its response beat is taken.
// ----------------------------------------------------------------------------
module aho_corasick_goto_table_build (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic [acgt_pkg::SYM_W-1:0]      req_symbol,
   input  logic [acgt_pkg::NODE_W-1:0]     req_node,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [1:0]                      rsp_status,
   output logic [acgt_pkg::NODE_W-1:0]     rsp_node_id,
   output logic [acgt_pkg::NODE_W-1:0]     rsp_fail_node,
   output logic [acgt_pkg::NODE_W-1:0]     rsp_depth
);

   localparam int NW = acgt_pkg::NODE_W;
   localparam int AW = acgt_pkg::GOTO_AW;
   localparam int CW = acgt_pkg::CNT_W;
   localparam int SW = acgt_pkg::SYM_W;

   // Memories. The goto table holds one entry per node and symbol; zero marks
   // an absent child until the build pass, after which zero means the root.
   logic [NW-1:0] goto_mem  [acgt_pkg::GOTO_DEPTH];
   logic [NW-1:0] fail_mem  [acgt_pkg::MAX_NODES];
   logic [NW-1:0] depth_mem [acgt_pkg::MAX_NODES];
   logic [NW-1:0] queue_mem [acgt_pkg::MAX_NODES];

   logic [NW-1:0] goto_rd_ff, fail_rd_ff, depth_rd_ff, queue_rd_ff;

   // Memory port controls.
   logic          goto_we, fail_we, depth_we, queue_we;
   logic [AW-1:0] goto_wa, goto_ra;
   logic [NW-1:0] goto_wd, fail_wa, fail_wd, fail_ra;
   logic [NW-1:0] depth_wa, depth_wd, depth_ra;
   logic [NW-1:0] queue_wa, queue_wd, queue_ra;

   acgt_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic [NW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] count_ff, count_in;
   logic          built_ff, built_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [NW-1:0] node_ff, node_in;
   logic [CW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0] i_ff, i_in, f_ff, f_in, j_ff, j_in;
   logic [SW-1:0] c_ff, c_in;
   logic [AW-1:0] addr_i_ff, addr_i_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in, rsp_status_ff, rsp_status_in;
   logic [NW-1:0] rsp_node_ff, rsp_node_in, rsp_fail_ff, rsp_fail_in;
   logic [NW-1:0] rsp_depth_ff, rsp_depth_in;

   // Shared address unit.
   logic [NW-1:0] au_node;
   logic [SW-1:0] au_sym;
   logic [AW-1:0] au_addr;

   acgt_addr u_addr (
      .clock (clock),
      .node  (au_node),
      .sym   (au_sym),
      .addr  (au_addr)
   );

   // Accept and refusal decode.
   logic accept, bad_sym, bad_node, refuse;

   assign req_ready = (state_ff == acgt_pkg::S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign bad_sym   = req_symbol > acgt_pkg::SYM_LAST;
   assign bad_node  = {1'b0, req_node} >= count_ff;

   always_comb begin
      case (req_command)
         acgt_pkg::CMD_APPEND: refuse = built_ff || bad_sym;
         acgt_pkg::CMD_END:    refuse = built_ff;
         acgt_pkg::CMD_BUILD:  refuse = built_ff;
         default:              refuse = !built_ff || bad_sym || bad_node;
      endcase
   end

   logic queue_empty, last_sym, table_full;
   assign queue_empty = head_ff == tail_ff;
   assign last_sym    = c_ff == acgt_pkg::SYM_LAST;
   assign table_full  = count_ff >= CW'(acgt_pkg::MAX_NODES);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acgt_pkg::S_CLEAR: begin
            if (clr_ff == AW'(acgt_pkg::GOTO_DEPTH - 1)) state_in = acgt_pkg::S_IDLE;
         end
         acgt_pkg::S_IDLE: begin
            if (accept && !refuse) begin
               if (req_command == acgt_pkg::CMD_BUILD) state_in = acgt_pkg::B_POP;
               else                                    state_in = acgt_pkg::S_RD;
            end
         end
         acgt_pkg::S_RD: state_in = acgt_pkg::S_DATA;
         acgt_pkg::S_DATA: begin
            if (cmd_ff == acgt_pkg::CMD_APPEND && goto_rd_ff != '0)
               state_in = acgt_pkg::S_DEPD;
            else
               state_in = acgt_pkg::S_IDLE;
         end
         acgt_pkg::S_DEPD: state_in = acgt_pkg::S_IDLE;
         acgt_pkg::B_POP: begin
            if (queue_empty) state_in = acgt_pkg::S_IDLE;
            else             state_in = acgt_pkg::B_POPD;
         end
         acgt_pkg::B_POPD: state_in = acgt_pkg::B_FAIL;
         acgt_pkg::B_FAIL: state_in = acgt_pkg::B_ADDR;
         acgt_pkg::B_ADDR: state_in = acgt_pkg::B_RDE;
         acgt_pkg::B_RDE:  state_in = acgt_pkg::B_RDF;
         acgt_pkg::B_RDF:  state_in = acgt_pkg::B_ACT;
         acgt_pkg::B_ACT: begin
            if (last_sym) state_in = acgt_pkg::B_POP;
            else          state_in = acgt_pkg::B_ADDR;
         end
         default: state_in = acgt_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_in    = clr_ff;
      cursor_in = cursor_ff;
      count_in  = count_ff;
      built_in  = built_ff;
      cmd_in    = cmd_ff;
      node_in   = node_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      i_in      = i_ff;
      f_in      = f_ff;
      j_in      = j_ff;
      c_in      = c_ff;
      addr_i_in = addr_i_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_fail_in   = rsp_fail_ff;
      rsp_depth_in  = rsp_depth_ff;

      au_node = i_ff;
      au_sym  = c_ff;

      goto_we  = 1'b0;  goto_wa  = addr_i_ff; goto_wd = goto_rd_ff; goto_ra = au_addr;
      fail_we  = 1'b0;  fail_wa  = j_ff;      fail_wd = '0;         fail_ra = node_ff;
      depth_we = 1'b0;  depth_wa = '0;        depth_wd = '0;        depth_ra = cursor_ff;
      queue_we = 1'b0;  queue_wa = '0;        queue_wd = '0;
      queue_ra = head_ff[NW-1:0];

      case (state_ff)
         acgt_pkg::S_CLEAR: begin
            // Sweep the goto table; the per-node tables ride along at the start.
            clr_in   = clr_ff + 1'b1;
            goto_we  = 1'b1;
            goto_wa  = clr_ff;
            goto_wd  = '0;
            fail_wa  = clr_ff[NW-1:0];
            depth_wa = clr_ff[NW-1:0];
            if (clr_ff < AW'(acgt_pkg::MAX_NODES)) begin
               fail_we  = 1'b1;
               depth_we = 1'b1;
            end
         end
         acgt_pkg::S_IDLE: begin
            au_node = (req_command == acgt_pkg::CMD_APPEND) ? cursor_ff : req_node;
            au_sym  = req_symbol;
            if (accept) begin
               cmd_in  = req_command;
               node_in = req_node;
               if (refuse) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = req_command;
                  rsp_status_in = acgt_pkg::ST_REFUSED;
                  rsp_node_in   = '0;
                  rsp_fail_in   = '0;
                  rsp_depth_in  = '0;
               end else if (req_command == acgt_pkg::CMD_BUILD) begin
                  // The root seeds the breadth-first queue.
                  queue_we = 1'b1;
                  head_in  = '0;
                  tail_in  = CW'(1);
               end
            end
         end
         acgt_pkg::S_RD: begin
            addr_i_in = au_addr;
            goto_ra   = au_addr;
            depth_ra  = (cmd_ff == acgt_pkg::CMD_LOOKUP) ? node_ff : cursor_ff;
         end
         acgt_pkg::S_DATA: begin
            rsp_kind_in  = cmd_ff;
            rsp_fail_in  = '0;
            depth_ra     = goto_rd_ff;
            j_in         = goto_rd_ff;
            case (cmd_ff)
               acgt_pkg::CMD_APPEND: begin
                  if (goto_rd_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_node_in  = cursor_ff;
                     if (table_full) begin
                        rsp_status_in = acgt_pkg::ST_FULL;
                        rsp_depth_in  = depth_rd_ff;
                     end else begin
                        // New child node: link it and give it parent depth plus one.
                        rsp_status_in = acgt_pkg::ST_OK;
                        goto_we       = 1'b1;
                        goto_wd       = count_ff[NW-1:0];
                        depth_we      = 1'b1;
                        depth_wa      = count_ff[NW-1:0];
                        depth_wd      = depth_rd_ff + 1'b1;
                        cursor_in     = count_ff[NW-1:0];
                        count_in      = count_ff + 1'b1;
                        rsp_node_in   = count_ff[NW-1:0];
                        rsp_depth_in  = depth_rd_ff + 1'b1;
                     end
                  end
               end
               acgt_pkg::CMD_END: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = acgt_pkg::ST_OK;
                  rsp_node_in   = cursor_ff;
                  rsp_depth_in  = depth_rd_ff;
                  cursor_in     = '0;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = acgt_pkg::ST_OK;
                  rsp_node_in   = goto_rd_ff;
                  rsp_fail_in   = fail_rd_ff;
                  rsp_depth_in  = depth_rd_ff;
               end
            endcase
         end
         acgt_pkg::S_DEPD: begin
            // Existing child: the cursor steps onto it.
            cursor_in     = j_ff;
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = cmd_ff;
            rsp_status_in = acgt_pkg::ST_OK;
            rsp_node_in   = j_ff;
            rsp_fail_in   = '0;
            rsp_depth_in  = depth_rd_ff;
         end
         acgt_pkg::B_POP: begin
            if (queue_empty) begin
               built_in      = 1'b1;
               cursor_in     = '0;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = acgt_pkg::CMD_BUILD;
               rsp_status_in = acgt_pkg::ST_OK;
               rsp_node_in   = '0;
               rsp_fail_in   = '0;
               rsp_depth_in  = '0;
            end
         end
         acgt_pkg::B_POPD: begin
            i_in    = queue_rd_ff;
            head_in = head_ff + 1'b1;
            fail_ra = queue_rd_ff;
         end
         acgt_pkg::B_FAIL: begin
            f_in = fail_rd_ff;
            c_in = '0;
         end
         acgt_pkg::B_ADDR: begin
            au_node = i_ff;
            au_sym  = c_ff;
         end
         acgt_pkg::B_RDE: begin
            // Entry of the current node; the failure node's row goes next.
            goto_ra   = au_addr;
            addr_i_in = au_addr;
            au_node   = f_ff;
            au_sym    = c_ff;
         end
         acgt_pkg::B_RDF: begin
            j_in    = goto_rd_ff;
            goto_ra = au_addr;
         end
         acgt_pkg::B_ACT: begin
            c_in = c_ff + 1'b1;
            if (j_ff != '0) begin
               fail_we = 1'b1;
               fail_wa = j_ff;
               fail_wd = (i_ff == '0) ? '0 : goto_rd_ff;
               if (tail_ff < CW'(acgt_pkg::MAX_NODES)) begin
                  queue_we = 1'b1;
                  queue_wa = tail_ff[NW-1:0];
                  queue_wd = j_ff;
                  tail_in  = tail_ff + 1'b1;
               end
            end else if (i_ff != '0) begin
               // Absent entry takes the failure node's transition.
               goto_we = 1'b1;
               goto_wa = addr_i_ff;
               goto_wd = goto_rd_ff;
            end
         end
         default: ;
      endcase
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (goto_we) goto_mem[goto_wa] <= goto_wd;
      goto_rd_ff <= goto_mem[goto_ra];
   end

   always_ff @(posedge clock) begin
      if (fail_we) fail_mem[fail_wa] <= fail_wd;
      fail_rd_ff <= fail_mem[fail_ra];
   end

   always_ff @(posedge clock) begin
      if (depth_we) depth_mem[depth_wa] <= depth_wd;
      depth_rd_ff <= depth_mem[depth_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      queue_rd_ff <= queue_mem[queue_ra];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acgt_pkg::S_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         count_ff     <= CW'(1);
         built_ff     <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         built_ff     <= built_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      node_ff       <= node_in;
      i_ff          <= i_in;
      f_ff          <= f_in;
      j_ff          <= j_in;
      c_ff          <= c_in;
      addr_i_ff     <= addr_i_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_fail_ff   <= rsp_fail_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_node_id   = rsp_node_ff;
   assign rsp_fail_node = rsp_fail_ff;
   assign rsp_depth     = rsp_depth_ff;

endmodule

FILE: rtl/acgt_checker.sv
// ----------------------------------------------------------------------------
// acgt_checker
// Port-level checks on the goto table build, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acgt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_kind,
   input logic [1:0]                   rsp_status,
   input logic [acgt_pkg::NODE_W-1:0]  rsp_node_id,
   input logic [acgt_pkg::NODE_W-1:0]  rsp_depth
);

   `AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_node_id))
   `AST_NEXT(a_busy_after_beat, req_valid && req_ready, !req_ready)
   `AST_IMPLY(a_status_code, rsp_valid, rsp_status != 2'd3)
   `AST_IMPLY(a_full_on_append, rsp_valid && rsp_status == acgt_pkg::ST_FULL, rsp_kind == acgt_pkg::CMD_APPEND)
   `AST_IMPLY(a_build_zero, rsp_valid && rsp_kind == acgt_pkg::CMD_BUILD, rsp_node_id == '0 && rsp_depth == '0)

endmodule

bind aho_corasick_goto_table_build acgt_checker u_acgt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_kind    (rsp_kind),
   .rsp_status  (rsp_status),
   .rsp_node_id (rsp_node_id),
   .rsp_depth   (rsp_depth)
);

FILE: test/tb_aho_corasick_goto_table_build.sv
// ----------------------------------------------------------------------------
// tb_aho_corasick_goto_table_build
// Grows a trie from directed and random patterns and one long chain that is
// sent while the receiver holds off. It then runs the failure-link build and
// reads the finished automaton with lookups. A cycle-free predictor keeps its
// own copy of the tables and checks every response beat field by field, in
// order.
// ----------------------------------------------------------------------------
module tb_aho_corasick_goto_table_build;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]                  cmd;
      logic [acgt_pkg::SYM_W-1:0]  sym;
      logic [acgt_pkg::NODE_W-1:0] node;
   } command_beat_type;

   typedef struct {
      logic [1:0]                  kind;
      logic [1:0]                  status;
      logic [acgt_pkg::NODE_W-1:0] node_id;
      logic [acgt_pkg::NODE_W-1:0] fail_node;
      logic [acgt_pkg::NODE_W-1:0] depth;
   } answer_beat_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_command = acgt_pkg::CMD_APPEND;
   logic [acgt_pkg::SYM_W-1:0]  req_symbol = '0;
   logic [acgt_pkg::NODE_W-1:0] req_node = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_kind;
   logic [1:0]                  rsp_status;
   logic [acgt_pkg::NODE_W-1:0] rsp_node_id;
   logic [acgt_pkg::NODE_W-1:0] rsp_fail_node;
   logic [acgt_pkg::NODE_W-1:0] rsp_depth;

   aho_corasick_goto_table_build dut (.*);

   always #10 clock = ~clock;

   // Commands waiting to be driven and answers waiting to come back.
   command_beat_type pending_cmds[$];
   answer_beat_type  awaited_answers[$];
   int               error_count = 0;

   // Idle behavior of the current phase, in percent, plus the long hold-off.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit hold_wanted = 0;
   int hold_left = 0;

   // ------------------------------------------------------------------------
   // Shadow automaton. Entry 0 in the goto table means "absent" until the
   // build runs, after which it means the root.
   // ------------------------------------------------------------------------
   logic [acgt_pkg::NODE_W-1:0] shadow_goto[0:acgt_pkg::GOTO_DEPTH-1];
   logic [acgt_pkg::NODE_W-1:0] shadow_fail[0:acgt_pkg::MAX_NODES-1];
   logic [acgt_pkg::NODE_W-1:0] shadow_depth[0:acgt_pkg::MAX_NODES-1];
   logic [acgt_pkg::NODE_W-1:0] shadow_queue[0:acgt_pkg::MAX_NODES-1];
   int                          shadow_count = 1;
   int                          shadow_cursor = 0;
   bit                          shadow_built = 0;

   initial begin
      for (int k = 0; k < acgt_pkg::GOTO_DEPTH; k++) shadow_goto[k] = '0;
      for (int k = 0; k < acgt_pkg::MAX_NODES; k++) begin
         shadow_fail[k] = '0;
         shadow_depth[k] = '0;
      end
   end

   // Breadth-first pass: failure links for present children, and absent
   // entries filled from the failure node's row (the root row is only read).
   function automatic void build_failure_links();
      int head;
      int tail;
      int cur;
      int fl;
      int child;
      head = 0;
      tail = 1;
      shadow_queue[0] = '0;
      while (head < tail) begin
         cur = shadow_queue[head];
         head++;
         fl = shadow_fail[cur];
         for (int c = 0; c < acgt_pkg::ALPHABET; c++) begin
            child = shadow_goto[cur*acgt_pkg::ALPHABET + c];
            if (child != 0) begin
               shadow_fail[child] = (cur == 0) ? '0
                                  : shadow_goto[fl*acgt_pkg::ALPHABET + c];
               if (tail < acgt_pkg::MAX_NODES) begin
                  shadow_queue[tail] = acgt_pkg::NODE_W'(child);
                  tail++;
               end
            end else if (cur != 0) begin
               shadow_goto[cur*acgt_pkg::ALPHABET + c] =
                  shadow_goto[fl*acgt_pkg::ALPHABET + c];
            end
         end
      end
   endfunction

   // Applies one accepted command to the shadow and returns its answer.
   function automatic answer_beat_type run_command(command_beat_type b);
      answer_beat_type a;
      int nxt;
      int idx;
      a.kind = b.cmd;
      a.status = acgt_pkg::ST_OK;
      a.node_id = '0;
      a.fail_node = '0;
      a.depth = '0;
      case (b.cmd)
         acgt_pkg::CMD_APPEND: begin
            if (shadow_built || b.sym >= acgt_pkg::ALPHABET) begin
               a.status = acgt_pkg::ST_REFUSED;
            end else begin
               idx = shadow_cursor*acgt_pkg::ALPHABET + b.sym;
               nxt = shadow_goto[idx];
               if (nxt == 0 && shadow_count >= acgt_pkg::MAX_NODES) begin
                  a.status = acgt_pkg::ST_FULL;
               end else begin
                  if (nxt == 0) begin
                     nxt = shadow_count;
                     shadow_count++;
                     shadow_goto[idx] = acgt_pkg::NODE_W'(nxt);
                     shadow_depth[nxt] = shadow_depth[shadow_cursor] + 1'b1;
                  end
                  shadow_cursor = nxt;
               end
               a.node_id = acgt_pkg::NODE_W'(shadow_cursor);
               a.depth = shadow_depth[shadow_cursor];
            end
         end
         acgt_pkg::CMD_END: begin
            if (shadow_built) begin
               a.status = acgt_pkg::ST_REFUSED;
            end else begin
               a.node_id = acgt_pkg::NODE_W'(shadow_cursor);
               a.depth = shadow_depth[shadow_cursor];
               shadow_cursor = 0;
            end
         end
         acgt_pkg::CMD_BUILD: begin
            if (shadow_built) begin
               a.status = acgt_pkg::ST_REFUSED;
            end else begin
               build_failure_links();
               shadow_built = 1;
               shadow_cursor = 0;
            end
         end
         default: begin
            if (!shadow_built || b.sym >= acgt_pkg::ALPHABET || b.node >= shadow_count) begin
               a.status = acgt_pkg::ST_REFUSED;
            end else begin
               a.node_id = shadow_goto[b.node*acgt_pkg::ALPHABET + b.sym];
               a.fail_node = shadow_fail[b.node];
               a.depth = shadow_depth[b.node];
            end
         end
      endcase
      return a;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sampling at the rising edge: a request beat is predicted the moment it
   // is taken, and a response beat is compared with the oldest prediction.
   // ------------------------------------------------------------------------
   bit req_taken = 0;

   always @(posedge clock) begin
      answer_beat_type want;
      command_beat_type b;
      if (!reset && req_valid && req_ready) begin
         b.cmd = req_command;
         b.sym = req_symbol;
         b.node = req_node;
         awaited_answers.push_back(run_command(b));
         req_taken = 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            $error("response beat with no command outstanding");
            error_count++;
         end else begin
            want = awaited_answers.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("status", want.status, rsp_status);
            check_field("node_id", want.node_id, rsp_node_id);
            check_field("fail_node", want.fail_node, rsp_fail_node);
            check_field("depth", want.depth, rsp_depth);
         end
      end
   end

   // Driver: a beat stays on the port until it is taken; after that the next
   // one goes out unless this cycle is picked as idle.
   always @(negedge clock) begin
      command_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            b = pending_cmds.pop_front();
            req_command <= b.cmd;
            req_symbol <= b.sym;
            req_node <= b.node;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 0;
   end

   // Receiver: random stalls, and on request one long hold-off so that the
   // block backs up and stops taking commands while the sender keeps offering.
   always @(negedge clock) begin
      if (hold_wanted) begin
         hold_left = 300;
         hold_wanted = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic void queue_cmd(logic [1:0] cmd, int sym, int node);
      command_beat_type b;
      b.cmd = cmd;
      b.sym = acgt_pkg::SYM_W'(sym);
      b.node = acgt_pkg::NODE_W'(node);
      pending_cmds.push_back(b);
   endfunction

   task automatic wait_all_answered();
      while (pending_cmds.size() != 0 || req_valid || awaited_answers.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Phases of the run.
   // ------------------------------------------------------------------------
   initial begin
      int len;
      int span;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed start: both symbol extremes, symbols outside the alphabet,
      // the empty pattern, an early lookup and re-walking an existing path.
      queue_cmd(acgt_pkg::CMD_APPEND, 0, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 25, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 26, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 31, 0);
      queue_cmd(acgt_pkg::CMD_END, 0, 0);
      queue_cmd(acgt_pkg::CMD_END, 0, 0);
      queue_cmd(acgt_pkg::CMD_LOOKUP, 0, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 0, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 25, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 1, 0);
      queue_cmd(acgt_pkg::CMD_END, 0, 4095);
      queue_cmd(acgt_pkg::CMD_APPEND, 25, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 0, 0);
      queue_cmd(acgt_pkg::CMD_END, 0, 0);
      wait_all_answered();

      // Random patterns, mostly well formed. Small alphabets make shared
      // prefixes, so failure links point somewhere other than the root.
      sender_idle_pct = 86;
      for (int p = 0; p < 60; p++) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
               0: queue_cmd(acgt_pkg::CMD_APPEND, $urandom_range(31, 26), $urandom);
               1: queue_cmd(acgt_pkg::CMD_LOOKUP, $urandom_range(31), $urandom);
               default: queue_cmd(acgt_pkg::CMD_END, $urandom_range(31), $urandom);
            endcase
         end else begin
            len = $urandom_range(8, 1);
            span = ($urandom_range(1) != 0) ? 3 : 25;
            for (int s = 0; s < len; s++)
               queue_cmd(acgt_pkg::CMD_APPEND, $urandom_range(span), $urandom);
            queue_cmd(acgt_pkg::CMD_END, $urandom_range(31), $urandom);
         end
      end
      wait_all_answered();

      // One long chain of appends. The receiver holds off at the start, so
      // the block backs up while the sender keeps offering.
      sender_idle_pct = 12;
      receiver_stall_pct = 12;
      hold_wanted = 1;
      for (int s = 0; s < 100; s++)
         queue_cmd(acgt_pkg::CMD_APPEND, $urandom_range(25), $urandom);
      queue_cmd(acgt_pkg::CMD_APPEND, 26, 0);
      queue_cmd(acgt_pkg::CMD_END, 0, 0);
      wait_all_answered();

      // Build, then every command that is out of phase afterwards.
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      queue_cmd(acgt_pkg::CMD_BUILD, 0, 0);
      queue_cmd(acgt_pkg::CMD_BUILD, 0, 0);
      queue_cmd(acgt_pkg::CMD_APPEND, 0, 0);
      queue_cmd(acgt_pkg::CMD_END, 0, 0);
      queue_cmd(acgt_pkg::CMD_LOOKUP, 0, 0);
      queue_cmd(acgt_pkg::CMD_LOOKUP, 25, 4095);
      queue_cmd(acgt_pkg::CMD_LOOKUP, 26, 1);
      wait_all_answered();

      // Lookups over the whole node range with a few bad symbols.
      receiver_stall_pct = 86;
      for (int k = 0; k < 180; k++) begin
         if (k == 90) begin
            wait_all_answered();
            receiver_stall_pct = 0;
         end
         if ($urandom_range(9) == 0)
            queue_cmd(acgt_pkg::CMD_LOOKUP, $urandom_range(31), $urandom);
         else if ($urandom_range(1) != 0)
            queue_cmd(acgt_pkg::CMD_LOOKUP, $urandom_range(25), $urandom_range(60));
         else
            queue_cmd(acgt_pkg::CMD_LOOKUP, $urandom_range(25), $urandom);
      end
      wait_all_answered();
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Clearing pass, trie growth and build together stay well under this.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
